// File: design/esfp_pkg.sv
// shared types and constants for the serial frame parser
package esfp_pkg;

  localparam int CHANNELS_DEF      = 8;
  localparam int TRAILER_ZEROS_DEF = 6;

  localparam logic [7:0] HDR0_BYTE = 8'hC0;
  localparam logic [7:0] HDR1_BYTE = 8'hA0;

  localparam int SAMPLE_W = 24;
  localparam int INDEX_W  = 3;

  typedef struct packed {
    logic                       sample_valid;
    logic [INDEX_W-1:0]         channel_index;
    logic signed [SAMPLE_W-1:0] sample_code;
    logic                       frame_done;
    logic                       trailer_error;
  } result_t;

endpackage

// File: design/esfp_parser.sv
// frame tracking state and per-byte result logic
module esfp_parser #(
  parameter int CHANNELS      = esfp_pkg::CHANNELS_DEF,
  parameter int TRAILER_ZEROS = esfp_pkg::TRAILER_ZEROS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output logic             has_result,
  output esfp_pkg::result_t res
);
  import esfp_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TZ_W = (TRAILER_ZEROS > 1) ? $clog2(TRAILER_ZEROS) : 1;

  localparam logic [2:0] ST_HUNT = 3'd0;
  localparam logic [2:0] ST_HDR1 = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_DATA = 3'd3;
  localparam logic [2:0] ST_IGN  = 3'd4;
  localparam logic [2:0] ST_TRL  = 3'd5;

  localparam logic [1:0] POS_HI  = 2'd0;
  localparam logic [1:0] POS_MID = 2'd1;
  localparam logic [1:0] POS_LO  = 2'd2;

  logic [2:0]      state, state_next;
  logic [1:0]      pos, pos_next;
  logic [CH_W-1:0] chan, chan_next;
  logic [TZ_W-1:0] tz, tz_next;
  logic [7:0]      held0, held1;
  logic            held0_we, held1_we;
  logic [CH_W+2:0] chan_ext;

  assign chan_ext = {3'b000, chan};

  always_comb begin
    state_next = state;
    pos_next   = pos;
    chan_next  = chan;
    tz_next    = tz;
    held0_we   = 1'b0;
    held1_we   = 1'b0;
    has_result = 1'b0;
    res        = '0;
    unique case (state)
      ST_HUNT: begin
        if (rx_byte == HDR0_BYTE) state_next = ST_HDR1;
      end
      ST_HDR1: begin
        state_next = (rx_byte == HDR1_BYTE) ? ST_SKIP : ST_HUNT;
      end
      ST_SKIP: begin
        state_next = ST_DATA;
        pos_next   = POS_HI;
        chan_next  = '0;
      end
      ST_DATA: begin
        if (pos == POS_HI) begin
          held0_we = 1'b1;
          pos_next = POS_MID;
        end else if (pos == POS_MID) begin
          held1_we = 1'b1;
          pos_next = POS_LO;
        end else begin
          has_result        = 1'b1;
          res.sample_valid  = 1'b1;
          res.channel_index = chan_ext[INDEX_W-1:0];
          res.sample_code   = {held0, held1, rx_byte};
          pos_next          = POS_HI;
          if (chan == CH_W'(CHANNELS - 1)) begin
            state_next = ST_IGN;
          end else begin
            chan_next = chan + 1'b1;
          end
        end
      end
      ST_IGN: begin
        state_next = ST_TRL;
        tz_next    = '0;
      end
      ST_TRL: begin
        if (rx_byte != 8'h00) begin
          has_result        = 1'b1;
          res.trailer_error = 1'b1;
          state_next        = ST_HUNT;
        end else if (tz == TZ_W'(TRAILER_ZEROS - 1)) begin
          has_result     = 1'b1;
          res.frame_done = 1'b1;
          state_next     = ST_HUNT;
        end else begin
          tz_next = tz + 1'b1;
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      pos   <= POS_HI;
      chan  <= '0;
      tz    <= '0;
    end else if (step) begin
      state <= state_next;
      pos   <= pos_next;
      chan  <= chan_next;
      tz    <= tz_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && held0_we) held0 <= rx_byte;
    if (step && held1_we) held1 <= rx_byte;
  end

endmodule

// File: design/esfp_out_reg.sv
// result register between parser logic and the output channel
module esfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  esfp_pkg::result_t res_in,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output esfp_pkg::result_t res_out
);
  import esfp_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) res_out <= res_in;
  end

endmodule

// File: design/eeg_serial_frame_parser.sv
// top level of the serial frame parser
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | rx_byte
//  out     | out_valid / out_ready| sample_valid, channel_index, sample_code,
//          |                      | frame_done, trailer_error
//
// one byte per cycle while in_ready is high; a result is registered on the edge that accepts its byte
// in_ready is high when the result register is empty or being emptied
// bytes that give no result pass without touching the output register
// reset returns the parser to the header hunt and empties the output
module eeg_serial_frame_parser #(
  parameter int CHANNELS      = esfp_pkg::CHANNELS_DEF,
  parameter int TRAILER_ZEROS = esfp_pkg::TRAILER_ZEROS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 sample_valid,
  output logic [esfp_pkg::INDEX_W-1:0]         channel_index,
  output logic signed [esfp_pkg::SAMPLE_W-1:0] sample_code,
  output logic                                 frame_done,
  output logic                                 trailer_error
);
  import esfp_pkg::*;

  logic    step;
  logic    has_result;
  result_t res;
  result_t res_q;

  assign step = in_valid && in_ready;

  esfp_parser #(
    .CHANNELS      (CHANNELS),
    .TRAILER_ZEROS (TRAILER_ZEROS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (rx_byte),
    .has_result (has_result),
    .res        (res)
  );

  esfp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && has_result),
    .res_in    (res),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign sample_valid  = res_q.sample_valid;
  assign channel_index = res_q.channel_index;
  assign sample_code   = res_q.sample_code;
  assign frame_done    = res_q.frame_done;
  assign trailer_error = res_q.trailer_error;

endmodule

// File: bench/tb_eeg_serial_frame_parser.sv
// self-checking bench for the serial frame parser: frame stimulus, parse prediction, result checks
class frame_scoreboard;
  localparam int DATA_PH    = 3;
  localparam int IGNORE_PH  = DATA_PH + 3 * esfp_pkg::CHANNELS_DEF;
  localparam int TRAILER_PH = IGNORE_PH + 1;
  localparam int LAST_PH    = TRAILER_PH + esfp_pkg::TRAILER_ZEROS_DEF - 1;

  int unsigned phase;
  logic [7:0] held [2];
  esfp_pkg::result_t parsed_q[$];
  int errors;

  function new();
    phase = 0;
    held[0] = 8'h00;
    held[1] = 8'h00;
    errors = 0;
  endfunction

  function void parse_byte(logic [7:0] b);
    esfp_pkg::result_t r;
    int unsigned off;
    r = '0;
    if (phase == 0) begin
      phase = (b == esfp_pkg::HDR0_BYTE) ? 1 : 0;
    end else if (phase == 1) begin
      phase = (b == esfp_pkg::HDR1_BYTE) ? 2 : 0;
    end else if (phase == 2) begin
      phase = DATA_PH;
    end else if (phase < IGNORE_PH) begin
      off = phase - DATA_PH;
      phase++;
      if (off % 3 < 2) begin
        held[off % 3] = b;
      end else begin
        r.sample_valid  = 1'b1;
        r.channel_index = 3'(off / 3);
        r.sample_code   = {held[0], held[1], b};
        parsed_q.push_back(r);
      end
    end else if (phase == IGNORE_PH) begin
      phase = TRAILER_PH;
    end else if (phase <= LAST_PH) begin
      if (b != 8'h00) begin
        // nonzero trailer byte drops the frame
        phase = 0;
        r.trailer_error = 1'b1;
        parsed_q.push_back(r);
      end else if (phase == LAST_PH) begin
        phase = 0;
        r.frame_done = 1'b1;
        parsed_q.push_back(r);
      end else begin
        phase++;
      end
    end else begin
      phase = 0;
    end
  endfunction

  function void match_result(esfp_pkg::result_t got);
    esfp_pkg::result_t want;
    if (parsed_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: valid=%0d ch=%0d code=%06h done=%0d err=%0d",
                 got.sample_valid, got.channel_index, got.sample_code,
                 got.frame_done, got.trailer_error);
      return;
    end
    want = parsed_q.pop_front();
    if (got.sample_valid !== want.sample_valid || got.channel_index !== want.channel_index ||
        got.sample_code !== want.sample_code || got.frame_done !== want.frame_done ||
        got.trailer_error !== want.trailer_error) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp %0d %0d %06h %0d %0d got %0d %0d %06h %0d %0d",
                 want.sample_valid, want.channel_index, want.sample_code,
                 want.frame_done, want.trailer_error,
                 got.sample_valid, got.channel_index, got.sample_code,
                 got.frame_done, got.trailer_error);
    end
  endfunction

  function int pending();
    return parsed_q.size();
  endfunction
endclass

module tb_eeg_serial_frame_parser;
  import esfp_pkg::*;

  typedef enum int {FRAME_GOOD, FRAME_BAD_HDR, FRAME_CUT, FRAME_BAD_TRAILER} frame_kind_e;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_ready;
  logic sample_valid;
  logic [INDEX_W-1:0] channel_index;
  logic signed [SAMPLE_W-1:0] sample_code;
  logic frame_done;
  logic trailer_error;

  frame_scoreboard sb;
  bit quiet;
  bit hold_req;
  int cycles;
  int items_sent;
  logic [23:0] edge_samples [8];
  logic [23:0] no_samples [8];

  eeg_serial_frame_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample_valid(sample_valid), .channel_index(channel_index),
    .sample_code(sample_code), .frame_done(frame_done), .trailer_error(trailer_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_eeg_serial_frame_parser: FAIL");
    $finish;
  end

  // receiver side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk) begin
    esfp_pkg::result_t got;
    if (!rst && out_valid && out_ready) begin
      got.sample_valid  = sample_valid;
      got.channel_index = channel_index;
      got.sample_code   = sample_code;
      got.frame_done    = frame_done;
      got.trailer_error = trailer_error;
      sb.match_result(got);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.parse_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return ($urandom_range(1) != 0) ? 24'h000000 : 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_frame(input frame_kind_e kind, input int fault_pos,
                            input bit use_preset, input logic [23:0] preset [8]);
    logic [23:0] s;
    logic [7:0] b;
    send_byte(HDR0_BYTE);
    if (kind == FRAME_BAD_HDR) begin
      do b = 8'($urandom); while (b == HDR1_BYTE);
      send_byte(b);
      return;
    end
    send_byte(HDR1_BYTE);
    send_byte(8'($urandom));
    for (int ch = 0; ch < CHANNELS_DEF; ch++) begin
      s = use_preset ? preset[ch] : pick_sample();
      if (kind == FRAME_CUT && ch == fault_pos) return;
      send_byte(s[23:16]);
      send_byte(s[15:8]);
      send_byte(s[7:0]);
    end
    send_byte(8'($urandom));
    for (int z = 0; z < TRAILER_ZEROS_DEF; z++) begin
      if (kind == FRAME_BAD_TRAILER && z == fault_pos) begin
        send_byte(8'($urandom_range(255, 1)));
        return;
      end
      send_byte(8'h00);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int pick;
    int start_count;
    sb = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    edge_samples = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                     24'h000001, 24'h555555, 24'hAAAAAA, 24'h123456};
    no_samples = '{default: 24'h0};
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // hunt noise, then a repeated first header byte that is consumed as the wrong second byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR0_BYTE);
    send_byte(HDR0_BYTE);
    send_byte(HDR1_BYTE);
    send_frame(FRAME_GOOD, 0, 1'b1, edge_samples);
    // random bytes run into the trailer of a frame, then a header pair and a frame sent with a bad last trailer byte
    send_byte(HDR0_BYTE);
    send_byte(HDR1_BYTE);
    send_byte(8'h5A);
    for (int k = 0; k < 3 * CHANNELS_DEF + 3; k++) send_byte(8'($urandom));
    send_byte(HDR0_BYTE);
    send_byte(HDR1_BYTE);
    send_frame(FRAME_BAD_TRAILER, TRAILER_ZEROS_DEF - 1, 1'b0, no_samples);
    drain_results();

    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      if (items_sent - start_count > 100 && items_sent - start_count < 140 && !hold_req)
        hold_req = 1'b1;
      quiet = (items_sent - start_count > 500 && items_sent - start_count < 700);
      if (items_sent - start_count > 800 && items_sent - start_count < 840)
        drain_results();
      pick = $urandom_range(99);
      if (pick < 60)
        send_frame(FRAME_GOOD, 0, 1'b0, no_samples);
      else if (pick < 75)
        send_frame(FRAME_BAD_TRAILER, $urandom_range(TRAILER_ZEROS_DEF - 1), 1'b0, no_samples);
      else if (pick < 83)
        send_frame(FRAME_BAD_HDR, 0, 1'b0, no_samples);
      else if (pick < 91)
        send_frame(FRAME_CUT, $urandom_range(CHANNELS_DEF - 1), 1'b0, no_samples);
      else
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
    end

    quiet = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_eeg_serial_frame_parser: PASS");
    end else begin
      $display("tb_eeg_serial_frame_parser: FAIL");
    end
    $finish;
  end
endmodule
